[sv/sto_pkg.sv]
`timescale 1ns / 1ps

package sto_pkg;

    localparam int HANDLE_W = 6;
    localparam int STAMP_W  = 32;
    localparam int ACTIVE_W = 7;

    // command codes
    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_UNLOAD   = 3'd1,
        OP_FREE     = 3'd2,
        OP_RESERVE  = 3'd3,
        OP_FIND     = 3'd4,
        OP_QUERY    = 3'd5
    } t_opcode;

    // result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_ERR      = 2'd1;
    localparam logic [1:0] STS_NO_FREE  = 2'd2;
    localparam logic [1:0] STS_NO_SPACE = 2'd3;

    // one table entry as held in memory
    typedef struct packed {
        logic               used;
        logic               loaded;
        logic               reserved;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // control from the sequencer to the victim tracker
    typedef struct packed {
        logic clear;
        logic sample;
        logic eligible;
    } t_vic_ctl;

endpackage

[sv/slot_table_with_oldest_victim.sv]
`timescale 1ns / 1ps

// Slot table with oldest-victim selection. All slot state (used, loaded and
// reserved marks and the 32-bit load stamp) lives in one memory with one
// write and one registered read port; a sequencer reads, modifies and writes
// entries back, one request at a time. After reset a clearing pass writes
// every entry, during which no request is taken (configuration writes are
// taken). Load with any slot and find_oldest sweep the memory one entry per
// cycle; load stops at the first free index, while find_oldest sweeps every
// entry to clear reservations, even beyond active_slots. A result waits in an
// output register; the next request is taken while it waits.

module slot_table_with_oldest_victim
    import sto_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ACTIVE_W-1:0] i_cfg_data,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_opcode,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_any_slot,
    input  logic [STAMP_W-1:0]  i_time_now,
    input  logic                i_space_ok,
    input  logic                i_slot_busy,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic                o_loaded_flag
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int WW = (CW > ACTIVE_W) ? CW : ACTIVE_W;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_SCAN,
        ST_PUT,
        ST_FIN,
        ST_RESP
    } t_state;

    t_state              r_state, n_state;
    logic [ACTIVE_W-1:0] r_active;

    // held request
    t_opcode             r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_any;
    logic [STAMP_W-1:0]  r_now;
    logic                r_space;
    logic                r_busy;

    // sweep control
    logic [AW-1:0]       r_idx;
    logic                r_rd_done;
    logic                r_pend;
    logic [AW-1:0]       r_pend_idx;
    logic [AW-1:0]       r_end, n_end;
    logic [AW-1:0]       r_slot, n_slot;

    // pending result and output register
    logic [1:0]          r_res_status, n_res_status;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic                r_res_flag, n_res_flag;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_out_flag;

    // memory ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [AW-1:0]       ram_raddr;
    t_entry              ram_rdata;

    t_vic_ctl            vic_ctl;
    logic                vic_have;
    logic [AW-1:0]       vic_best;

    logic                in_acc;
    logic                out_free;
    logic [WW-1:0]       live;
    logic [WW-1:0]       live_m1;
    logic [WW-1:0]       h_w;
    logic [AW-1:0]       h_addr;
    logic                h_bad;
    logic [31:0]         slot_w;
    logic [31:0]         best_w;
    t_entry              fill;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // clamp the active count to the table size
    assign live    = (WW'(r_active) > WW'(SLOT_COUNT)) ? WW'(SLOT_COUNT) : WW'(r_active);
    assign live_m1 = live - WW'(1);
    assign h_w     = WW'(r_handle);
    assign h_addr  = h_w[AW-1:0];
    assign h_bad   = (h_w >= live);
    assign slot_w  = 32'(r_slot);
    assign best_w  = 32'(vic_best);

    // entry written by a load: taken and stamped, or left cleared
    always_comb begin
        fill = '0;
        if (r_space) begin
            fill.used   = 1'b1;
            fill.loaded = 1'b1;
            fill.stamp  = r_now;
        end
    end

    sto_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sto_victim #(
        .IDX_W (AW)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (vic_ctl),
        .i_idx   (r_pend_idx),
        .i_stamp (ram_rdata.stamp),
        .o_have  (vic_have),
        .o_best  (vic_best)
    );

    // sequencer: decode, memory accesses and result
    always_comb begin
        n_state      = r_state;
        n_end        = r_end;
        n_slot       = r_slot;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_flag   = r_res_flag;
        ram_we       = 1'b0;
        ram_waddr    = h_addr;
        ram_wdata    = '0;
        ram_raddr    = r_idx;
        vic_ctl      = '0;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                if (r_idx == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ram_raddr    = h_addr;
                n_res_status = STS_ERR;
                n_res_handle = '0;
                n_res_flag   = 1'b0;
                n_state      = ST_RESP;
                case (r_op)
                    OP_LOAD: begin
                        if (r_any) begin
                            if (live == '0) begin
                                n_res_status = STS_NO_FREE;
                            end else begin
                                n_end   = live_m1[AW-1:0];
                                n_state = ST_SCAN;
                            end
                        end else if (!h_bad && !r_busy) begin
                            ram_we    = 1'b1;
                            ram_wdata = fill;
                            if (r_space) begin
                                n_res_status = STS_OK;
                                n_res_handle = r_handle;
                            end else begin
                                n_res_status = STS_NO_SPACE;
                            end
                        end
                    end
                    OP_UNLOAD: begin
                        if (!h_bad && !r_busy) begin
                            n_state = ST_MOD;
                        end
                    end
                    OP_FREE: begin
                        if (!h_bad && !r_busy) begin
                            ram_we       = 1'b1;
                            n_res_status = STS_OK;
                        end
                    end
                    OP_RESERVE, OP_QUERY: begin
                        if (!h_bad) begin
                            n_state = ST_MOD;
                        end
                    end
                    OP_FIND: begin
                        vic_ctl.clear = 1'b1;
                        n_end         = LAST;
                        n_state       = ST_SCAN;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_MOD: begin
                ram_wdata    = ram_rdata;
                n_res_status = STS_OK;
                n_state      = ST_RESP;
                case (r_op)
                    OP_UNLOAD: begin
                        ram_wdata.loaded = 1'b0;
                        ram_we = ram_rdata.used && ram_rdata.loaded;
                    end
                    OP_RESERVE: begin
                        ram_wdata.reserved = 1'b1;
                        ram_we = ram_rdata.used && ram_rdata.loaded;
                    end
                    OP_QUERY: begin
                        if (ram_rdata.used) begin
                            n_res_flag = ram_rdata.loaded;
                        end else begin
                            n_res_status = STS_ERR;
                        end
                    end
                    default: begin
                        n_res_status = STS_ERR;
                    end
                endcase
            end
            ST_SCAN: begin
                if (r_op == OP_LOAD) begin
                    // stop at the first unused slot
                    if (r_pend && !ram_rdata.used) begin
                        n_slot  = r_pend_idx;
                        n_state = ST_PUT;
                    end else if (r_pend && (r_pend_idx == r_end)) begin
                        n_res_status = STS_NO_FREE;
                        n_state      = ST_RESP;
                    end
                end else begin
                    // write back with the reservation dropped, offer as candidate
                    if (r_pend) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_pend_idx;
                        ram_wdata          = ram_rdata;
                        ram_wdata.reserved = 1'b0;
                        vic_ctl.sample     = 1'b1;
                        vic_ctl.eligible   = (WW'(r_pend_idx) < live) && ram_rdata.used
                                             && ram_rdata.loaded && !ram_rdata.reserved;
                        if (r_pend_idx == r_end) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = fill;
                if (r_space) begin
                    n_res_status = STS_OK;
                    n_res_handle = slot_w[HANDLE_W-1:0];
                end else begin
                    n_res_status = STS_NO_SPACE;
                end
                n_state = ST_RESP;
            end
            ST_FIN: begin
                if (vic_have) begin
                    n_res_status = STS_OK;
                    n_res_handle = best_w[HANDLE_W-1:0];
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state, counters, request fields and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_active    <= ACTIVE_W'(64);
            r_idx       <= '0;
            r_rd_done   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            // advance the sweep address
            case (r_state)
                ST_INIT: begin
                    r_idx <= (r_idx == LAST) ? '0 : r_idx + AW'(1);
                end
                ST_EXEC: begin
                    r_idx     <= '0;
                    r_rd_done <= 1'b0;
                    r_pend    <= 1'b0;
                end
                ST_SCAN: begin
                    r_pend <= !r_rd_done;
                    if (!r_rd_done) begin
                        if (r_idx == r_end) begin
                            r_rd_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
            // present a result, drop it once taken
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_end        <= n_end;
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_flag   <= n_res_flag;
        r_pend_idx   <= r_idx;
        if (in_acc) begin
            r_op     <= t_opcode'(i_opcode);
            r_handle <= i_handle;
            r_any    <= i_any_slot;
            r_now    <= i_time_now;
            r_space  <= i_space_ok;
            r_busy   <= i_slot_busy;
        end
        if (r_state == ST_RESP && out_free) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_flag   <= r_res_flag;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_handle_out  = r_out_handle;
    assign o_loaded_flag = r_out_flag;

endmodule

[sv/sto_ram.sv]
`timescale 1ns / 1ps

module sto_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sto_victim.sv]
`timescale 1ns / 1ps

module sto_victim
    import sto_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_vic_ctl           i_ctl,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [STAMP_W-1:0] i_stamp,
    output logic               o_have,
    output logic [IDX_W-1:0]   o_best
);

    logic               r_have;
    logic [IDX_W-1:0]   r_best;
    logic [STAMP_W-1:0] r_best_stamp;
    logic               take;

    // strictly smaller stamp wins, so ties keep the lower index seen first
    assign take = i_ctl.sample && i_ctl.eligible && (!r_have || (i_stamp < r_best_stamp));

    // track the oldest candidate over the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
        if (take) begin
            r_best       <= i_idx;
            r_best_stamp <= i_stamp;
        end
    end

    assign o_have = r_have;
    assign o_best = r_best;

endmodule

[tb/tb_slot_table_with_oldest_victim.sv]
`timescale 1ns / 1ps

module tb_slot_table_with_oldest_victim;
    import sto_pkg::*;

    localparam int          SLOTS        = 64;
    localparam logic [31:0] STAMP_MAX    = 32'hFFFF_FFFF;
    localparam logic [2:0]  OP_BAD6      = 3'd6;
    localparam logic [2:0]  OP_BAD7      = 3'd7;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          RAND_PER_SET = 84;

    typedef struct {
        logic [2:0]          op;
        logic [HANDLE_W-1:0] handle;
        logic                any;
        logic [STAMP_W-1:0]  now;
        logic                space;
        logic                busy;
    } t_slot_req;

    typedef struct {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle;
        logic                loaded;
    } t_slot_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [ACTIVE_W-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [2:0]          i_opcode = '0;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic                i_any_slot = 1'b0;
    logic [STAMP_W-1:0]  i_time_now = '0;
    logic                i_space_ok = 1'b0;
    logic                i_slot_busy = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic                o_loaded_flag;

    // shadow copy of the slot table and the active count
    bit                 slot_used     [SLOTS];
    bit                 slot_loaded   [SLOTS];
    bit                 slot_reserved [SLOTS];
    bit [STAMP_W-1:0]   slot_stamp    [SLOTS];
    logic [ACTIVE_W-1:0] active_cfg = 7'd64;

    t_slot_result pending_results [$];
    int           err_count     = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         hold_trigger  = 1'b0;
    logic         hold_seen     = 1'b0;
    int           hold_left     = 0;

    slot_table_with_oldest_victim #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_handle      (i_handle),
        .i_any_slot    (i_any_slot),
        .i_time_now    (i_time_now),
        .i_space_ok    (i_space_ok),
        .i_slot_busy   (i_slot_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_loaded_flag (o_loaded_flag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned live_slots();
        return (active_cfg > SLOTS) ? SLOTS : active_cfg;
    endfunction

    function automatic void wipe_slot(input int unsigned idx);
        slot_used[idx]     = 1'b0;
        slot_loaded[idx]   = 1'b0;
        slot_reserved[idx] = 1'b0;
        slot_stamp[idx]    = '0;
    endfunction

    // apply one request to the shadow table and return the result it gives
    function automatic t_slot_result apply_slot_cmd(input t_slot_req r);
        t_slot_result     res;
        int unsigned      n;
        int unsigned      slot;
        bit               found;
        bit [STAMP_W-1:0] best_stamp;
        res.status = STS_ERR;
        res.handle = '0;
        res.loaded = 1'b0;
        n          = live_slots();
        slot       = 0;
        found      = 1'b0;
        best_stamp = '0;
        case (r.op)
            OP_LOAD: begin
                if (r.any) begin
                    for (int i = 0; i < n; i++)
                        if (!found && !slot_used[i]) begin
                            slot  = i;
                            found = 1'b1;
                        end
                end else if (r.handle < n && !r.busy) begin
                    slot  = 32'(r.handle);
                    found = 1'b1;
                end
                if (!found) begin
                    res.status = r.any ? STS_NO_FREE : STS_ERR;
                end else begin
                    wipe_slot(slot);
                    if (!r.space) begin
                        res.status = STS_NO_SPACE;
                    end else begin
                        slot_used[slot]   = 1'b1;
                        slot_loaded[slot] = 1'b1;
                        slot_stamp[slot]  = r.now;
                        res.status        = STS_OK;
                        res.handle        = HANDLE_W'(slot);
                    end
                end
            end
            OP_UNLOAD: begin
                if (r.handle < n && !r.busy) begin
                    if (slot_used[r.handle] && slot_loaded[r.handle])
                        slot_loaded[r.handle] = 1'b0;
                    res.status = STS_OK;
                end
            end
            OP_FREE: begin
                if (r.handle < n && !r.busy) begin
                    wipe_slot(32'(r.handle));
                    res.status = STS_OK;
                end
            end
            OP_RESERVE: begin
                if (r.handle < n) begin
                    if (slot_used[r.handle] && slot_loaded[r.handle])
                        slot_reserved[r.handle] = 1'b1;
                    res.status = STS_OK;
                end
            end
            OP_FIND: begin
                // strict compare keeps the lowest index on a tie
                for (int i = 0; i < n; i++)
                    if (slot_used[i] && slot_loaded[i] && !slot_reserved[i] &&
                        (!found || slot_stamp[i] < best_stamp)) begin
                        found      = 1'b1;
                        slot       = i;
                        best_stamp = slot_stamp[i];
                    end
                for (int i = 0; i < SLOTS; i++)
                    slot_reserved[i] = 1'b0;
                if (found) begin
                    res.status = STS_OK;
                    res.handle = HANDLE_W'(slot);
                end
            end
            OP_QUERY: begin
                if (r.handle < n && slot_used[r.handle]) begin
                    res.status = STS_OK;
                    res.loaded = slot_loaded[r.handle];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // offer one request, wait for it to be taken, then log its expected result
    task automatic send_req(input logic [2:0] op, input logic [HANDLE_W-1:0] h,
                            input logic any, input logic [STAMP_W-1:0] now,
                            input logic space, input logic busy);
        t_slot_req   r;
        int unsigned gap;
        r.op    = op;
        r.handle = h;
        r.any   = any;
        r.now   = now;
        r.space = space;
        r.busy  = busy;
        gap     = 0;
        while (gap < 8 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= r.op;
        i_handle    <= r.handle;
        i_any_slot  <= r.any;
        i_time_now  <= r.now;
        i_space_ok  <= r.space;
        i_slot_busy <= r.busy;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_slot_cmd(r));
    endtask

    // drain, then write the active slot count
    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_cfg = value;
    endtask

    task automatic send_random_req();
        logic [2:0]          op;
        logic [HANDLE_W-1:0] h;
        logic [STAMP_W-1:0]  now;
        int unsigned         n;
        int unsigned         pick;
        n    = live_slots();
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_LOAD;
        else if (pick < 40) op = OP_UNLOAD;
        else if (pick < 50) op = OP_FREE;
        else if (pick < 65) op = OP_RESERVE;
        else if (pick < 80) op = OP_FIND;
        else if (pick < 95) op = OP_QUERY;
        else if (pick < 98) op = OP_BAD6;
        else                op = OP_BAD7;
        // mostly in range, now and then anywhere
        if (n != 0 && $urandom_range(0, 99) < 85)
            h = HANDLE_W'($urandom_range(0, n - 1));
        else
            h = HANDLE_W'($urandom_range(0, SLOTS - 1));
        // small stamps give ties for the oldest search
        pick = $urandom_range(0, 9);
        if (pick == 0)      now = '0;
        else if (pick == 1) now = STAMP_MAX;
        else if (pick < 6)  now = $urandom_range(0, 15);
        else                now = $urandom;
        send_req(op, h, 1'($urandom_range(0, 1)), now,
                 $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 15);
    endtask

    // every opcode and the corner cases at the reset slot count
    task automatic test_directed_ops();
        send_req(OP_QUERY,   6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_LOAD,    6'd63, 1'b1, STAMP_MAX, 1'b1, 1'b0);
        send_req(OP_LOAD,    6'd63, 1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_LOAD,    6'd5,  1'b0, 32'd7,     1'b1, 1'b1);
        send_req(OP_LOAD,    6'd5,  1'b0, 32'd7,     1'b0, 1'b0);
        send_req(OP_LOAD,    6'd0,  1'b1, 32'd0,     1'b1, 1'b0);
        send_req(OP_QUERY,   6'd63, 1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_RESERVE, 6'd1,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_UNLOAD,  6'd1,  1'b0, 32'd0,     1'b1, 1'b1);
        send_req(OP_UNLOAD,  6'd1,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_QUERY,   6'd1,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_RESERVE, 6'd1,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_UNLOAD,  6'd2,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_FREE,    6'd63, 1'b0, 32'd0,     1'b1, 1'b1);
        send_req(OP_FREE,    6'd63, 1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_QUERY,   6'd63, 1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_BAD6,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
        send_req(OP_BAD7,    6'd63, 1'b1, STAMP_MAX, 1'b0, 1'b1);
        send_req(OP_LOAD,    6'd0,  1'b0, 32'd5,     1'b1, 1'b0);
        send_req(OP_LOAD,    6'd40, 1'b1, 32'd1,     1'b1, 1'b1);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0,     1'b1, 1'b0);
    endtask

    // empty table range, single slot and counts above the table size
    task automatic test_active_limits();
        write_active(7'd0);
        send_req(OP_LOAD,    6'd0,  1'b1, 32'd3, 1'b1, 1'b0);
        send_req(OP_LOAD,    6'd0,  1'b0, 32'd3, 1'b1, 1'b0);
        send_req(OP_RESERVE, 6'd0,  1'b0, 32'd0, 1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0, 1'b1, 1'b0);
        send_req(OP_QUERY,   6'd0,  1'b0, 32'd0, 1'b1, 1'b0);
        write_active(7'd1);
        send_req(OP_LOAD,    6'd1,  1'b0, 32'd9, 1'b1, 1'b0);
        send_req(OP_LOAD,    6'd0,  1'b1, 32'd9, 1'b1, 1'b0);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0, 1'b1, 1'b0);
        write_active(7'd127);
        send_req(OP_LOAD,    6'd63, 1'b0, 32'd2, 1'b1, 1'b0);
        send_req(OP_QUERY,   6'd63, 1'b0, 32'd0, 1'b1, 1'b0);
        write_active(7'd65);
        send_req(OP_FIND,    6'd0,  1'b0, 32'd0, 1'b1, 1'b0);
    endtask

    // random mix over three idling modes and several slot counts
    task automatic test_random_traffic();
        logic [ACTIVE_W-1:0] counts [5];
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 35 : (m == 1) ? 70 : 0;
            recv_idle_pct = (m == 0) ? 70 : (m == 1) ? 35 : 0;
            counts = '{7'd64, 7'd8, 7'd127, 7'd2, 7'($urandom_range(0, 127))};
            for (int s = 0; s < 5; s++) begin
                write_active(counts[s]);
                repeat (RAND_PER_SET) send_random_req();
            end
        end
    endtask

    // hold the result side off while requests keep coming
    task automatic test_result_backpressure();
        write_active(7'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_trigger <= ~hold_trigger;
        repeat (24) send_random_req();
    endtask

    initial begin
        send_idle_pct = 35;
        recv_idle_pct = 70;
        for (int i = 0; i < SLOTS; i++)
            wipe_slot(i);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_active_limits();
        test_random_traffic();
        test_result_backpressure();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // check each result taken, then choose the next stall value
    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d handle %0d loaded %0d",
                         $time, o_status, o_handle_out, o_loaded_flag);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    err_count++;
                end
                if (o_handle_out !== want.handle) begin
                    $display("%0t: handle_out expected %0d actual %0d",
                             $time, want.handle, o_handle_out);
                    err_count++;
                end
                if (o_loaded_flag !== want.loaded) begin
                    $display("%0t: loaded_flag expected %0d actual %0d",
                             $time, want.loaded, o_loaded_flag);
                    err_count++;
                end
            end
        end
        if (hold_trigger != hold_seen) begin
            hold_seen   <= hold_trigger;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
sv/sto_pkg.sv
sv/sto_ram.sv
sv/sto_victim.sv
sv/slot_table_with_oldest_victim.sv
tb/tb_slot_table_with_oldest_victim.sv
